// ===== src/gda_pkg.sv =====
package gda_pkg;

  // defaults for the top level parameters
  localparam int MAX_YEAR_DEF    = 9999;
  localparam int OFFSET_BITS_DEF = 16;

  // field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YIN_W   = 14;
  // working year, holds any year up to the widest range plus one cycle step
  localparam int YEAR_W  = 17;

  // the calendar repeats after this many days and years
  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;

  // month codes used by the walk
  localparam logic [MONTH_W-1:0] JAN = 4'd1;
  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_CYCLE,
    S_MONTH,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    DOP_HOLD,
    DOP_LOAD,
    DOP_SUB_CYC,
    DOP_ADD_CYC,
    DOP_SUB_DIM,
    DOP_ADD_PREV
  } day_op_t;

  typedef enum logic [2:0] {
    COP_HOLD,
    COP_LOAD,
    COP_MOD,
    COP_UP400,
    COP_DN400,
    COP_NEXT,
    COP_PREV
  } cal_op_t;

  // status of the day accumulator
  typedef struct packed {
    logic over_month;
    logic non_pos;
    logic over_cyc;
    logic under_cyc;
  } day_flags_t;

  // status of the month and year registers
  typedef struct packed {
    logic             mod_done;
    logic [DAY_W-1:0] dim;
    logic [DAY_W-1:0] dim_prev;
    logic             month_year_ok;
    logic             up_fail;
    logic             dn_fail;
    logic             next_fail;
    logic             prev_fail;
  } cal_flags_t;

  // month length, zero for a month code that means nothing
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] mon,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== src/gregorian_date_add_days.sv =====
// Gregorian date plus a signed day offset.
// Input channel (in_valid/in_ready) carries one word: start_day, start_month,
// start_year and offset_days (two's complement, negative moves back).
// Output channel (out_valid/out_ready) carries result_day, result_month,
// result_year and range_error. range_error is 1 when the start date is not
// a real date or the result leaves years 1..MAX_YEAR; the date then echoes
// the start date.
// One word is in work at a time; in_ready is high only while idle.
// From accept to out_valid the sequencer reduces the year modulo 400 and
// checks the date, takes whole 400-year steps, walks month by month and
// closes. All day arithmetic goes through one shared adder, stepped one
// month per cycle by the sequencer.
// A new word is accepted the cycle after the result is taken.
// While out_ready is low the result is held and no new word is accepted.
// Synchronous reset returns the sequencer to idle with out_valid low.
module gregorian_date_add_days
  import gda_pkg::*;
#(
  parameter int MAX_YEAR    = MAX_YEAR_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [DAY_W-1:0]              start_day,
  input  logic [MONTH_W-1:0]            start_month,
  input  logic [YIN_W-1:0]              start_year,
  input  logic signed [OFFSET_BITS-1:0] offset_days,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DAY_W-1:0]              result_day,
  output logic [MONTH_W-1:0]            result_month,
  output logic [YIN_W-1:0]              result_year,
  output logic                          range_error
);

  state_t     state;
  state_t     state_next;
  day_op_t    day_op;
  cal_op_t    cal_op;
  day_flags_t dflags;
  cal_flags_t cflags;
  logic       fin_ok;
  logic       fin_err;
  logic       in_acc;

  logic [DAY_W-1:0]              sd;
  logic [MONTH_W-1:0]            sm;
  logic [YIN_W-1:0]              sy;
  logic signed [OFFSET_BITS-1:0] off;
  logic [DAY_W-1:0]              day_low;
  logic [MONTH_W-1:0]            month;
  logic [YEAR_W-1:0]             year;
  logic                          start_ok;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign start_ok = cflags.month_year_ok && (sd != '0) && (sd <= cflags.dim);

  // latch the input word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sd  <= start_day;
      sm  <= start_month;
      sy  <= start_year;
      off <= offset_days;
    end
  end

  gda_day_unit #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_day (
    .clk      (clk),
    .op       (day_op),
    .start_day(sd),
    .offset   (off),
    .dim      (cflags.dim),
    .dim_prev (cflags.dim_prev),
    .flags    (dflags),
    .day_low  (day_low)
  );

  gda_cal_unit #(
    .MAX_YEAR(MAX_YEAR)
  ) u_cal (
    .clk        (clk),
    .op         (cal_op),
    .start_month(start_month),
    .start_year (start_year),
    .flags      (cflags),
    .month      (month),
    .year       (year)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (cflags.mod_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = start_ok ? S_CYCLE : S_DONE;
      S_CYCLE: begin
        if (dflags.over_cyc) begin
          state_next = cflags.up_fail ? S_DONE : S_CYCLE;
        end else if (dflags.under_cyc) begin
          state_next = cflags.dn_fail ? S_DONE : S_CYCLE;
        end else begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        if (dflags.over_month) begin
          state_next = cflags.next_fail ? S_DONE : S_MONTH;
        end else if (dflags.non_pos) begin
          state_next = cflags.prev_fail ? S_DONE : S_MONTH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    day_op  = DOP_HOLD;
    cal_op  = COP_HOLD;
    fin_ok  = 1'b0;
    fin_err = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cal_op = COP_LOAD;
        end
      end
      S_MOD: cal_op = COP_MOD;
      S_CHECK: begin
        if (start_ok) begin
          day_op = DOP_LOAD;
        end else begin
          fin_err = 1'b1;
        end
      end
      S_CYCLE: begin
        if (dflags.over_cyc) begin
          if (cflags.up_fail) begin
            fin_err = 1'b1;
          end else begin
            day_op = DOP_SUB_CYC;
            cal_op = COP_UP400;
          end
        end else if (dflags.under_cyc) begin
          if (cflags.dn_fail) begin
            fin_err = 1'b1;
          end else begin
            day_op = DOP_ADD_CYC;
            cal_op = COP_DN400;
          end
        end
      end
      S_MONTH: begin
        if (dflags.over_month) begin
          if (cflags.next_fail) begin
            fin_err = 1'b1;
          end else begin
            day_op = DOP_SUB_DIM;
            cal_op = COP_NEXT;
          end
        end else if (dflags.non_pos) begin
          if (cflags.prev_fail) begin
            fin_err = 1'b1;
          end else begin
            day_op = DOP_ADD_PREV;
            cal_op = COP_PREV;
          end
        end else begin
          fin_ok = 1'b1;
        end
      end
      default: begin
        day_op = DOP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (fin_ok) begin
      result_day   <= day_low;
      result_month <= month;
      result_year  <= year[YIN_W-1:0];
      range_error  <= 1'b0;
    end else if (fin_err) begin
      result_day   <= sd;
      result_month <= sm;
      result_year  <= sy;
      range_error  <= 1'b1;
    end
  end

  assign out_valid = (state == S_DONE);

  // an accepted word is never answered in the next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !out_valid)
    else $error("result shown right after accept");

  // a good result has a nonzero day and a month from JAN to DEC
  a_result_sane: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !range_error) |->
      (result_day != '0) && (result_month >= JAN) && (result_month <= DEC))
    else $error("result date out of calendar range");

  // the year remainder is ready before any stepping
  a_mod_before_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_CYCLE || state == S_MONTH || state == S_CHECK) |-> cflags.mod_done)
    else $error("walk started before year remainder settled");

endmodule

// ===== src/gda_day_unit.sv =====
module gda_day_unit
  import gda_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  day_op_t                       op,
  input  logic [DAY_W-1:0]              start_day,
  input  logic signed [OFFSET_BITS-1:0] offset,
  input  logic [DAY_W-1:0]              dim,
  input  logic [DAY_W-1:0]              dim_prev,
  output day_flags_t                    flags,
  output logic [DAY_W-1:0]              day_low
);

  // wide enough for start day plus offset and for a full cycle of days
  localparam int DW = ((OFFSET_BITS > 19) ? OFFSET_BITS : 19) + 2;

  localparam logic signed [DW-1:0] CYC_POS = DW'(CYCLE_DAYS);
  localparam logic signed [DW-1:0] CYC_NEG = -CYC_POS;

  logic signed [DW-1:0] day;
  logic signed [DW-1:0] day_next;
  logic signed [DW-1:0] opa;
  logic signed [DW-1:0] opb;
  logic signed [DW-1:0] sum;
  logic signed [DW-1:0] dim_s;
  logic signed [DW-1:0] dim_prev_s;
  logic signed [DW-1:0] off_s;

  assign dim_s      = $signed({{(DW-DAY_W){1'b0}}, dim});
  assign dim_prev_s = $signed({{(DW-DAY_W){1'b0}}, dim_prev});
  assign off_s      = $signed({{(DW-OFFSET_BITS){offset[OFFSET_BITS-1]}}, offset});

  // operand select for the shared adder
  always_comb begin
    opa = day;
    opb = '0;
    case (op)
      DOP_LOAD: begin
        opa = $signed({{(DW-DAY_W){1'b0}}, start_day});
        opb = off_s;
      end
      DOP_SUB_CYC:  opb = CYC_NEG;
      DOP_ADD_CYC:  opb = CYC_POS;
      DOP_SUB_DIM:  opb = -dim_s;
      DOP_ADD_PREV: opb = dim_prev_s;
      default:      opb = '0;
    endcase
  end

  assign sum      = opa + opb;
  assign day_next = (op == DOP_HOLD) ? day : sum;

  always_ff @(posedge clk) begin
    day <= day_next;
  end

  // compares on the accumulator
  assign flags.over_month = (day > dim_s);
  assign flags.non_pos    = day[DW-1] || (day == '0);
  assign flags.over_cyc   = (day > CYC_POS);
  assign flags.under_cyc  = (day < CYC_NEG);

  assign day_low = day[DAY_W-1:0];

endmodule

// ===== src/gda_cal_unit.sv =====
module gda_cal_unit
  import gda_pkg::*;
#(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic               clk,
  input  cal_op_t            op,
  input  logic [MONTH_W-1:0] start_month,
  input  logic [YIN_W-1:0]   start_year,
  output cal_flags_t         flags,
  output logic [MONTH_W-1:0] month,
  output logic [YEAR_W-1:0]  year
);

  localparam logic [YEAR_W:0]  MAXY   = (YEAR_W+1)'(MAX_YEAR);
  localparam logic [YEAR_W:0]  STEPY  = (YEAR_W+1)'(CYCLE_YEARS);
  localparam logic [YIN_W-1:0] STEPR  = YIN_W'(CYCLE_YEARS);
  localparam logic [YIN_W-1:0] LASTR  = YIN_W'(CYCLE_YEARS - 1);

  // year modulo 400, worked down from the start year, then kept in step
  logic [YIN_W-1:0]   rem;
  logic [YIN_W-1:0]   rem_next;
  logic [MONTH_W-1:0] month_next;
  logic [YEAR_W-1:0]  year_next;
  logic [YEAR_W:0]    year_w;
  logic               leap;
  logic [MONTH_W-1:0] prev_month;

  assign year_w = {1'b0, year};

  always_comb begin
    month_next = month;
    year_next  = year;
    rem_next   = rem;
    case (op)
      COP_LOAD: begin
        month_next = start_month;
        year_next  = YEAR_W'(start_year);
        rem_next   = start_year;
      end
      COP_MOD: begin
        if (rem >= STEPR) begin
          rem_next = rem - STEPR;
        end
      end
      COP_UP400: year_next = year + YEAR_W'(CYCLE_YEARS);
      COP_DN400: year_next = year - YEAR_W'(CYCLE_YEARS);
      COP_NEXT: begin
        if (month == DEC) begin
          month_next = JAN;
          year_next  = year + 1'b1;
          rem_next   = (rem == LASTR) ? '0 : rem + 1'b1;
        end else begin
          month_next = month + 1'b1;
        end
      end
      COP_PREV: begin
        if (month == JAN) begin
          month_next = DEC;
          year_next  = year - 1'b1;
          rem_next   = (rem == '0) ? LASTR : rem - 1'b1;
        end else begin
          month_next = month - 1'b1;
        end
      end
      default: begin
        month_next = month;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    month <= month_next;
    year  <= year_next;
    rem   <= rem_next;
  end

  // leap year from the remainder: multiple of 4, not a century unless 400
  assign leap = (rem[1:0] == 2'd0) && (rem != YIN_W'(100)) &&
                (rem != YIN_W'(200)) && (rem != YIN_W'(300));

  assign prev_month = (month == JAN) ? DEC : month - 1'b1;

  assign flags.mod_done      = (rem < STEPR);
  assign flags.dim           = days_in(month, leap);
  assign flags.dim_prev      = days_in(prev_month, leap);
  assign flags.month_year_ok = (month >= JAN) && (month <= DEC) &&
                               (year_w >= (YEAR_W+1)'(1)) && (year_w <= MAXY);
  assign flags.up_fail       = ((year_w + STEPY) > MAXY);
  assign flags.dn_fail       = (year_w <= STEPY);
  assign flags.next_fail     = (month == DEC) && (year_w >= MAXY);
  assign flags.prev_fail     = (month == JAN) && (year_w <= (YEAR_W+1)'(1));

  // the remainder is below 400 whenever months are stepped
  a_rem_reduced: assert property (@(posedge clk)
    (op == COP_NEXT || op == COP_PREV) |-> (rem < STEPR))
    else $error("year remainder not reduced during month step");

endmodule

// ===== tb/gregorian_date_add_days_test.sv =====
`timescale 1ns / 1ps

module gregorian_date_add_days_test;
  import gda_pkg::*;

  localparam int OFF_W          = OFFSET_BITS_DEF;
  localparam int MAX_YR         = MAX_YEAR_DEF;
  localparam int RANDOM_WORDS   = 520;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;

  // one result word as the block should deliver it
  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YIN_W-1:0]   year;
    logic               range_error;
  } date_word_t;

  class date_scoreboard;
    date_word_t  pending_dates[$];
    int unsigned mismatches;

    static function longint month_length(longint mon, longint yr);
      bit leap;
      leap = (yr % 400 == 0) || (yr % 4 == 0 && yr % 100 != 0);
      case (mon)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        int'(FEB):             return leap ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    // date reached by moving off days from the start date
    static function date_word_t shift_date(logic [DAY_W-1:0] sd, logic [MONTH_W-1:0] sm,
                                           logic [YIN_W-1:0] sy,
                                           logic signed [OFF_W-1:0] off);
      longint     day;
      longint     mon;
      longint     yr;
      bit         bad;
      date_word_t res;
      mon = sm;
      yr  = sy;
      bad = 1'b0;
      if (mon < int'(JAN) || mon > int'(DEC) || yr < 1 || yr > MAX_YR ||
          sd < 1 || longint'(sd) > month_length(mon, yr)) begin
        bad = 1'b1;
      end else begin
        day = longint'(sd);
        day += longint'(off);
        // whole 400-year cycles, the calendar repeats after each
        while (!bad && day > CYCLE_DAYS) begin
          day -= CYCLE_DAYS;
          yr  += CYCLE_YEARS;
          if (yr > MAX_YR) bad = 1'b1;
        end
        while (!bad && day < -CYCLE_DAYS) begin
          day += CYCLE_DAYS;
          yr  -= CYCLE_YEARS;
          if (yr < 1) bad = 1'b1;
        end
        // walk forward a month at a time
        while (!bad && day > month_length(mon, yr)) begin
          day -= month_length(mon, yr);
          mon++;
          if (mon > int'(DEC)) begin
            mon = int'(JAN);
            yr++;
            if (yr > MAX_YR) bad = 1'b1;
          end
        end
        // walk back, adding the length of the month before
        while (!bad && day <= 0) begin
          mon--;
          if (mon < int'(JAN)) begin
            mon = int'(DEC);
            yr--;
            if (yr < 1) bad = 1'b1;
          end
          if (!bad) day += month_length(mon, yr);
        end
      end
      if (bad) begin
        res.day         = sd;
        res.month       = sm;
        res.year        = sy;
        res.range_error = 1'b1;
      end else begin
        res.day         = day[DAY_W-1:0];
        res.month       = mon[MONTH_W-1:0];
        res.year        = yr[YIN_W-1:0];
        res.range_error = 1'b0;
      end
      return res;
    endfunction

    function void note_start(logic [DAY_W-1:0] sd, logic [MONTH_W-1:0] sm,
                             logic [YIN_W-1:0] sy, logic signed [OFF_W-1:0] off);
      pending_dates.push_back(shift_date(sd, sm, sy, off));
    endfunction

    function void check_result(logic [DAY_W-1:0] rd, logic [MONTH_W-1:0] rm,
                               logic [YIN_W-1:0] ry, logic re);
      date_word_t want;
      if (pending_dates.size() == 0) begin
        $error("unexpected result word: day %0d month %0d year %0d range_error %0b",
               rd, rm, ry, re);
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      if (want.day !== rd) begin
        $error("result_day: expected %0d, actual %0d", want.day, rd);
        mismatches++;
      end
      if (want.month !== rm) begin
        $error("result_month: expected %0d, actual %0d", want.month, rm);
        mismatches++;
      end
      if (want.year !== ry) begin
        $error("result_year: expected %0d, actual %0d", want.year, ry);
        mismatches++;
      end
      if (want.range_error !== re) begin
        $error("range_error: expected %0b, actual %0b", want.range_error, re);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [DAY_W-1:0]        start_day;
  logic [MONTH_W-1:0]      start_month;
  logic [YIN_W-1:0]        start_year;
  logic signed [OFF_W-1:0] offset_days;
  logic                    out_valid;
  logic                    out_ready;
  logic [DAY_W-1:0]        result_day;
  logic [MONTH_W-1:0]      result_month;
  logic [YIN_W-1:0]        result_year;
  logic                    range_error;

  bit             idle_on = 1'b1;
  int unsigned    stall_cycles = 0;
  date_scoreboard board = new;

  gregorian_date_add_days DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_day    (start_day),
    .start_month  (start_month),
    .start_year   (start_year),
    .offset_days  (offset_days),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year),
    .range_error  (range_error)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // present one start word and hold it until it is taken
  task automatic send_word(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                           input logic [YIN_W-1:0] y, input logic signed [OFF_W-1:0] o);
    while (idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    start_day   <= d;
    start_month <= m;
    start_year  <= y;
    offset_days <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_start(d, m, y, o);
  endtask

  // hold off the sender until every result word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending_dates.size() != 0);
  endtask

  // stimulus
  initial begin
    logic [DAY_W-1:0]        d;
    logic [MONTH_W-1:0]      m;
    logic [YIN_W-1:0]        y;
    logic signed [OFF_W-1:0] o;
    int unsigned             pick;
    int unsigned             span;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    start_day   <= '0;
    start_month <= '0;
    start_year  <= '0;
    offset_days <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // range ends, zero offset and the largest offsets
    send_word(5'd1, 4'd1, 14'd1, 16'sd0);
    send_word(5'd31, 4'd12, 14'd9999, 16'sd0);
    send_word(5'd31, 4'd12, 14'd9999, 16'sd1);
    send_word(5'd1, 4'd1, 14'd1, -16'sd1);
    send_word(5'd1, 4'd1, 14'd1, 16'sd32767);
    send_word(5'd31, 4'd12, 14'd9999, 16'sh8000);
    send_word(5'd15, 4'd6, 14'd9990, 16'sd32767);
    send_word(5'd10, 4'd3, 14'd40, 16'sh8000);
    // leap and century rules
    send_word(5'd28, 4'd2, 14'd2024, 16'sd1);
    send_word(5'd29, 4'd2, 14'd2024, 16'sd1);
    send_word(5'd28, 4'd2, 14'd1900, 16'sd1);
    send_word(5'd28, 4'd2, 14'd2000, 16'sd1);
    send_word(5'd1, 4'd3, 14'd2000, -16'sd1);
    send_word(5'd1, 4'd3, 14'd2100, -16'sd1);
    send_word(5'd31, 4'd12, 14'd1999, 16'sd1);
    send_word(5'd1, 4'd1, 14'd2000, -16'sd1);
    send_word(5'd31, 4'd1, 14'd2001, 16'sd1);
    // start dates that do not exist
    send_word(5'd29, 4'd2, 14'd2023, 16'sd1);
    send_word(5'd31, 4'd4, 14'd2020, 16'sd5);
    send_word(5'd0, 4'd5, 14'd2020, 16'sd5);
    send_word(5'd31, 4'd0, 14'd2020, -16'sd5);
    send_word(5'd12, 4'd13, 14'd2020, 16'sd5);
    send_word(5'd31, 4'd15, 14'd16383, -16'sd1);
    send_word(5'd7, 4'd7, 14'd0, 16'sd100);
    send_word(5'd7, 4'd7, 14'd10000, -16'sd100);
    wait_drained();

    // random words, mostly real dates
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idle_on = !(i >= 150 && i < 270);
      if (i == 350) wait_drained();
      pick = $urandom_range(99);
      if (pick < 85) begin
        span = $urandom_range(9);
        if (span == 0) y = YIN_W'($urandom_range(1, 150));
        else if (span == 1) y = YIN_W'($urandom_range(MAX_YR - 150, MAX_YR));
        else y = YIN_W'($urandom_range(1, MAX_YR));
        m = MONTH_W'($urandom_range(1, 12));
        d = DAY_W'($urandom_range(1, int'(date_scoreboard::month_length(m, y))));
        if ($urandom_range(4) == 0) d = DAY_W'(date_scoreboard::month_length(m, y));
        span = $urandom_range(99);
        if (span < 50) o = OFF_W'(int'($urandom_range(0, 800)) - 400);
        else if (span < 85) o = OFF_W'($urandom);
        else if ($urandom_range(1) == 1) o = OFF_W'(32767 - int'($urandom_range(0, 60)));
        else o = OFF_W'(-32768 + int'($urandom_range(0, 60)));
      end else if (pick < 92) begin
        // day one past the end of its month
        y = YIN_W'($urandom_range(1, MAX_YR));
        m = MONTH_W'($urandom_range(1, 12));
        d = DAY_W'(date_scoreboard::month_length(m, y) + 1);
        o = OFF_W'($urandom);
      end else begin
        d = DAY_W'($urandom);
        m = MONTH_W'($urandom);
        y = YIN_W'($urandom);
        o = OFF_W'($urandom);
      end
      send_word(d, m, y, o);
    end
    in_valid <= 1'b0;
    idle_on = 1'b1;

    // drain and settle
    while (board.pending_dates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_dates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: take words, stalling at random while idle_on is set
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        board.check_result(result_day, result_month, result_year, range_error);
      end
      out_ready <= idle_on ? ($urandom_range(99) >= 15) : 1'b1;
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== gregorian_date_add_days.f =====
src/gda_pkg.sv
src/gda_day_unit.sv
src/gda_cal_unit.sv
src/gregorian_date_add_days.sv
tb/gregorian_date_add_days_test.sv
